/* hw/rtl/ppta_pkg.sv */
// Shared widths, types and constants for the polygon perimeter and triangle area block.
package ppta_pkg;

   localparam int SIDE_W        = 12;
   localparam int PERIM_W       = 19;
   localparam int AREA_W        = 26;
   localparam int COUNT_W       = 8;
   localparam int SUM_W         = 20;
   // Perimeter of three sides fits in this many bits.
   localparam int TRI_SUM_W     = 14;
   localparam int PROD_W        = 56;
   localparam int MUL_A_W       = PROD_W - TRI_SUM_W;
   localparam int ROOT_W        = PROD_W / 2;
   localparam int REM_W         = ROOT_W + 2;
   localparam int SQRT_BITS_PER_CYCLE = 2;
   localparam int SQRT_CYCLES   = ROOT_W / SQRT_BITS_PER_CYCLE;
   localparam int SQRT_CNT_W    = $clog2(SQRT_CYCLES);
   localparam int DEF_MAX_SIDES = 128;

   localparam logic [SUM_W-1:0] PERIM_MAX = SUM_W'((1 << PERIM_W) - 1);

   typedef logic [SIDE_W-1:0]  side_type;
   typedef logic [PERIM_W-1:0] perim_type;
   typedef logic [AREA_W-1:0]  area_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [ROOT_W-1:0]  root_type;

   // Status of the square root unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

/* hw/rtl/ppta_if.sv */
// Valid/ready channel interfaces for side items and result items.
interface ppta_req_if;
   import ppta_pkg::*;

   logic     valid;
   logic     ready;
   side_type side_length;
   logic     last_side;

   modport source (output valid, output side_length, output last_side, input ready);
   modport sink   (input valid, input side_length, input last_side, output ready);
endinterface

interface ppta_rsp_if;
   import ppta_pkg::*;

   logic      valid;
   logic      ready;
   perim_type perimeter;
   logic      is_triangle;
   area_type  area;

   modport source (output valid, output perimeter, output is_triangle, output area,
                   input ready);
   modport sink   (input valid, input perimeter, input is_triangle, input area,
                   output ready);
endinterface

/* hw/rtl/ppta_isqrt.sv */
// Iterative integer square root, two root bits per cycle.
module ppta_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  ppta_pkg::prod_type         value,
   output ppta_pkg::root_type         root,
   output ppta_pkg::sqrt_status_type  status
);
   import ppta_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   prod_type              val_ff, val_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   root_type              root_ff, root_in;

   prod_type              step_val;
   logic [REM_W-1:0]      step_rem;
   root_type              step_root;

   // Digit recurrence: bring down two radicand bits, try (root << 2) | 1.
   always_comb begin
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      step_val  = val_ff;
      step_rem  = rem_ff;
      step_root = root_ff;
      for (int i = 0; i < SQRT_BITS_PER_CYCLE; i++) begin
         rem_t = {step_rem[REM_W-3:0], step_val[PROD_W-1 -: 2]};
         trial = {step_root, 2'b01};
         if (rem_t >= trial) begin
            step_rem  = rem_t - trial;
            step_root = {step_root[ROOT_W-2:0], 1'b1};
         end else begin
            step_rem  = rem_t;
            step_root = {step_root[ROOT_W-2:0], 1'b0};
         end
         step_val = {step_val[PROD_W-3:0], 2'b00};
      end
   end

   // Next-state logic for the iteration counter and the working registers.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in  = step_val;
         rem_in  = step_rem;
         root_in = step_root;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQRT_CNT_W'(SQRT_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

   // A start always launches a fresh pass from the first digit.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy_ff && cnt_ff == '0))
      else $error("square root did not start after a start pulse");

   // Done marks the end of a pass and the unit is free at that point.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("square root done without a finished pass");

   // The sequencer never restarts the unit in the middle of a pass.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("square root restarted while busy");

endmodule

/* hw/rtl/polygon_perimeter_triangle_area.sv */
// Top level: side accumulator, sequencer, shared multiplier and result register.
// Side items that are not the last are taken one per cycle, back to back, while the sequencer is idle.
// A final side item passes through EVAL and DONE to the result register when the sides do
// not form a triangle, and through EVAL, MUL1, MUL2, MUL3, SQRT and DONE when they do: three
// passes through the one 42x14 multiplier, then the square root unit at two root bits per cycle.
// Reset (synchronous, active high) clears the side count, the running sum, the
// sequencer and the result valid; the first three sides hold no value until written.
module polygon_perimeter_triangle_area #(
   parameter int MAX_SIDES = ppta_pkg::DEF_MAX_SIDES
) (
   input  logic          clock,
   input  logic          reset,
   ppta_req_if.sink      req_ch,
   ppta_rsp_if.source    rsp_ch
);
   import ppta_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_MUL3 = 3'd4;
   localparam logic [2:0] ST_SQRT = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   side_type             first_ff [3];
   logic [SUM_W-1:0]     p_ff;
   logic                 three_ff;
   logic                 tri_ff;
   logic [TRI_SUM_W-1:0] diff_ff [3];
   prod_type             prod_ff;
   area_type             area_ff;
   logic                 rsp_valid_ff;
   perim_type            rsp_perim_ff;
   logic                 rsp_tri_ff;
   area_type             rsp_area_ff;

   logic                 accept;
   logic                 take_side;
   logic [COUNT_W-1:0]   count_upd;
   logic [SUM_W-1:0]     sum_upd;
   logic                 tri_eval;
   logic [TRI_SUM_W-1:0] mul_b;
   prod_type             mul_res;
   logic                 sqrt_start;
   root_type             sqrt_root;
   sqrt_status_type      sqrt_stat;
   logic                 rsp_load;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign take_side    = (count_ff < COUNT_W'(MAX_SIDES));

   // Side accumulation; sides past the limit leave count and sum alone.
   always_comb begin
      count_upd = count_ff;
      sum_upd   = sum_ff;
      if (take_side) begin
         count_upd = count_ff + 1'b1;
         sum_upd   = sum_ff + SUM_W'(req_ch.side_length);
      end
      count_in = count_ff;
      sum_in   = sum_ff;
      if (accept) begin
         if (req_ch.last_side) begin
            count_in = '0;
            sum_in   = '0;
         end else begin
            count_in = count_upd;
            sum_in   = sum_upd;
         end
      end
   end

   // Triangle test on the first three sides; degenerate cases pass.
   always_comb begin
      logic [SIDE_W:0] sum_bc;
      logic [SIDE_W:0] sum_ac;
      logic [SIDE_W:0] sum_ab;
      sum_bc   = {1'b0, first_ff[1]} + {1'b0, first_ff[2]};
      sum_ac   = {1'b0, first_ff[0]} + {1'b0, first_ff[2]};
      sum_ab   = {1'b0, first_ff[0]} + {1'b0, first_ff[1]};
      tri_eval = three_ff &&
                 !(({1'b0, first_ff[0]} > sum_bc) ||
                   ({1'b0, first_ff[1]} > sum_ac) ||
                   ({1'b0, first_ff[2]} > sum_ab));
   end

   // Shared multiplier: the product so far times one factor (P - 2x).
   always_comb begin
      case (state_ff)
         ST_MUL1: mul_b = diff_ff[0];
         ST_MUL2: mul_b = diff_ff[1];
         ST_MUL3: mul_b = diff_ff[2];
         default: mul_b = '0;
      endcase
   end
   assign mul_res    = PROD_W'(prod_ff[MUL_A_W-1:0]) * PROD_W'(mul_b);
   assign sqrt_start = (state_ff == ST_MUL3);

   ppta_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .value  (mul_res),
      .root   (sqrt_root),
      .status (sqrt_stat)
   );

   // Result register is loaded once it is empty or being drained.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Sequencer for the final side.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_ch.last_side) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in = tri_eval ? ST_MUL1 : ST_DONE;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_SQRT;
         ST_SQRT: begin
            if (sqrt_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept && take_side && (count_ff < COUNT_W'(3))) begin
         first_ff[count_ff[1:0]] <= req_ch.side_length;
      end
      if (accept && req_ch.last_side) begin
         p_ff     <= sum_upd;
         three_ff <= (count_upd == COUNT_W'(3));
      end
      case (state_ff)
         ST_EVAL: begin
            tri_ff  <= tri_eval;
            area_ff <= '0;
            prod_ff <= PROD_W'(p_ff[TRI_SUM_W-1:0]);
            for (int k = 0; k < 3; k++) begin
               diff_ff[k] <= p_ff[TRI_SUM_W-1:0] - {1'b0, first_ff[k], 1'b0};
            end
         end
         ST_MUL1, ST_MUL2, ST_MUL3: begin
            prod_ff <= mul_res;
         end
         ST_SQRT: begin
            if (sqrt_stat.done) begin
               area_ff <= sqrt_root[ROOT_W-1:2];
            end
         end
         default: begin
         end
      endcase
      if (rsp_load) begin
         rsp_perim_ff <= (p_ff > PERIM_MAX) ? '1 : p_ff[PERIM_W-1:0];
         rsp_tri_ff   <= tri_ff;
         rsp_area_ff  <= area_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.perimeter   = rsp_perim_ff;
   assign rsp_ch.is_triangle = rsp_tri_ff;
   assign rsp_ch.area        = rsp_area_ff;

   // No side item is taken while a final side is being worked on.
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ch.ready)
      else $error("side item accepted during evaluation");

   // A polygon that is not a triangle reports no area.
   a_area_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tri_ff) |-> (rsp_area_ff == '0))
      else $error("non-triangle result with nonzero area");

   // The side count never passes the limit.
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SIDES))
      else $error("side count above limit");

   // A finished square root moves the sequencer on to the result.
   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && sqrt_stat.done) |=> (state_ff == ST_DONE))
      else $error("square root result not taken");

   // While the sequencer waits on the square root, the unit is working.
   a_sqrt_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && !sqrt_stat.done) |-> sqrt_stat.busy)
      else $error("square root idle while the sequencer waits");

endmodule

/* test/tb.sv */
// Self-checking testbench for the polygon perimeter and triangle area block.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppta_pkg::*;

   typedef struct packed {
      perim_type perimeter;
      logic      is_triangle;
      area_type  area;
   } heron_result_type;

   logic clock;
   logic reset;

   ppta_req_if req_ch ();
   ppta_rsp_if rsp_ch ();

   polygon_perimeter_triangle_area #(
      .MAX_SIDES (DEF_MAX_SIDES)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Predictor state for the polygon being assembled.
   int unsigned      poly_side_count;
   logic [SUM_W-1:0] poly_sum;
   side_type         first_three [3];

   heron_result_type results_due [$];
   heron_result_type due;
   int unsigned      fail_count;

   // Handshake shaping controls.
   bit          req_calm;
   bit          req_rush;
   bit          rsp_calm;
   int unsigned rsp_hold;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Floor of the square root, two bits of the operand per step.
   function automatic logic [63:0] floor_sqrt64(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bit_val;
      root    = '0;
      bit_val = 64'd1 << 62;
      while (bit_val > v)
         bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v    = v - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   // Update the polygon state with one accepted side and queue the result on the last one.
   function automatic void predict_side(input side_type side, input logic last);
      heron_result_type res;
      int unsigned      a, b, c;
      logic [63:0]      p, prod;
      if (poly_side_count < DEF_MAX_SIDES) begin
         if (poly_side_count < 3)
            first_three[poly_side_count] = side;
         poly_sum        = poly_sum + SUM_W'(side);
         poly_side_count = poly_side_count + 1;
      end
      if (!last)
         return;
      res.is_triangle = 1'b0;
      res.area        = '0;
      if (poly_side_count == 3) begin
         a = first_three[0];
         b = first_three[1];
         c = first_three[2];
         res.is_triangle = !(a > b + c || b > a + c || c > a + b);
      end
      if (res.is_triangle) begin
         p    = 64'(poly_sum);
         prod = p * (p - 2 * 64'(first_three[0]));
         prod = prod * (p - 2 * 64'(first_three[1]));
         prod = prod * (p - 2 * 64'(first_three[2]));
         res.area = area_type'(floor_sqrt64(prod) >> 2);
      end
      res.perimeter   = perim_type'((poly_sum > PERIM_MAX) ? PERIM_MAX : poly_sum);
      results_due.push_back(res);
      poly_side_count = 0;
      poly_sum        = '0;
   endfunction

   // Predict on every accepted side and check every accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            predict_side(req_ch.side_length, req_ch.last_side);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (results_due.size() == 0) begin
               $error("result item with no expected result waiting");
               fail_count++;
            end else begin
               due = results_due.pop_front();
               if (rsp_ch.perimeter !== due.perimeter) begin
                  $error("perimeter: expected %0d, got %0d", due.perimeter, rsp_ch.perimeter);
                  fail_count++;
               end
               if (rsp_ch.is_triangle !== due.is_triangle) begin
                  $error("is_triangle: expected %0d, got %0d", due.is_triangle,
                         rsp_ch.is_triangle);
                  fail_count++;
               end
               if (rsp_ch.area !== due.area) begin
                  $error("area: expected %0d, got %0d", due.area, rsp_ch.area);
                  fail_count++;
               end
            end
         end
      end
   end

   // Result receiver: a random stall (none while calm) before each item, or a long hold when requested.
   initial begin
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 31) == 0)
            rsp_calm = !rsp_calm;
         if (rsp_hold != 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end else begin
            stall = rsp_calm ? 0 : $urandom_range(0, 14);
         end
         @(negedge clock);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Offer one side item after a random gap (none while calm or rushed) and wait until it is accepted.
   task automatic send_side(input side_type side, input logic last);
      int unsigned gap;
      if ($urandom_range(0, 31) == 0)
         req_calm = !req_calm;
      gap = (req_calm || req_rush) ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.side_length <= side;
      req_ch.last_side   <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_triangle(input side_type a, input side_type b, input side_type c);
      send_side(a, 1'b0);
      send_side(b, 1'b0);
      send_side(c, 1'b1);
   endtask

   // Stop offering items and wait until every expected result has arrived.
   task automatic wait_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
   endtask

   // Side length of random bit width, so small and large values both show up.
   function automatic side_type rand_side();
      int unsigned w;
      w = $urandom_range(1, SIDE_W);
      return side_type'($urandom_range((1 << w) - 1, 0));
   endfunction

   task automatic test_extremes();
      send_triangle(12'hFFF, 12'hFFF, 12'hFFF);
      send_triangle(12'h000, 12'h000, 12'h000);
      send_triangle(12'hAAA, 12'h555, 12'hAAA);
      send_triangle(12'h800, 12'h7FF, 12'h001);
      send_triangle(12'h001, 12'h001, 12'h001);
   endtask

   // Degenerate triangles pass with zero area; others give a clear flag.
   task automatic test_degenerate_and_invalid();
      send_triangle(12'd1, 12'd2, 12'd3);
      send_triangle(12'd4095, 12'd2000, 12'd2095);
      send_triangle(12'd0, 12'd4095, 12'd4095);
      send_triangle(12'd1, 12'd2, 12'd4);
      send_triangle(12'd0, 12'd4095, 12'd1);
   endtask

   // Polygons with fewer or more than three sides.
   task automatic test_side_counts();
      send_side(12'hFFF, 1'b1);
      send_side(12'h123, 1'b0);
      send_side(12'hFFF, 1'b1);
      for (int n = 4; n <= 5; n++)
         for (int i = 0; i < n; i++)
            send_side(12'd100, i == n - 1);
   endtask

   // Sides beyond the limit are ignored, the final mark still ends the polygon.
   task automatic test_too_many_sides();
      for (int i = 0; i < DEF_MAX_SIDES; i++)
         send_side(12'hFFF, i == DEF_MAX_SIDES - 1);
      for (int i = 0; i < DEF_MAX_SIDES + 1; i++)
         send_side(12'hFFF, i == DEF_MAX_SIDES);
      for (int i = 0; i < DEF_MAX_SIDES + 3; i++)
         send_side(rand_side(), i == DEF_MAX_SIDES + 2);
   endtask

   // Hold the result side for a long stretch while sides keep coming back to back.
   task automatic test_backpressure();
      wait_drain();
      rsp_hold = 300;
      send_triangle(12'd300, 12'd400, 12'd500);
      req_rush = 1'b1;
      for (int i = 0; i < 20; i++)
         send_triangle(12'd48 + 12'(i), 12'd64, 12'd80);
      req_rush = 1'b0;
      wait_drain();
   endtask

   // Mostly valid triangles with random content, plus other polygons and noise.
   task automatic test_random_polygons();
      side_type    sides [$];
      side_type    a, b, c;
      int unsigned kind, lo, hi, rot, n, item_count;
      bit          paused;
      item_count = 0;
      paused     = 1'b0;
      while (item_count < 400) begin
         kind = $urandom_range(0, 15);
         sides.delete();
         a = rand_side();
         b = rand_side();
         if (kind <= 8) begin
            lo = (a > b) ? a - b : b - a;
            hi = (a + b > 4095) ? 4095 : a + b;
            c  = side_type'($urandom_range(hi, lo));
         end else if (kind <= 10) begin
            c = rand_side();
         end else if (kind <= 12) begin
            a = a >> 1;
            b = b >> 1;
            c = a + b;
         end
         if (kind <= 12) begin
            rot = $urandom_range(0, 2);
            if (rot == 0) sides = '{a, b, c};
            else if (rot == 1) sides = '{b, c, a};
            else sides = '{c, a, b};
         end else begin
            n = (kind == 13) ? $urandom_range(1, 2) : $urandom_range(4, 10);
            for (int i = 0; i < n; i++)
               sides.push_back(rand_side());
         end
         foreach (sides[i])
            send_side(sides[i], i == sides.size() - 1);
         item_count += sides.size();
         // Pause the sender once until every result is back.
         if (!paused && item_count >= 200) begin
            paused = 1'b1;
            wait_drain();
         end
      end
   endtask

   // Run the tests in turn and report.
   initial begin
      fail_count         = 0;
      poly_side_count    = 0;
      poly_sum           = '0;
      req_calm           = 1'b0;
      req_rush           = 1'b0;
      rsp_calm           = 1'b0;
      rsp_hold           = 0;
      req_ch.valid       = 1'b0;
      req_ch.side_length = '0;
      req_ch.last_side   = 1'b0;
      reset              = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_degenerate_and_invalid();
      test_side_counts();
      test_too_many_sides();
      test_backpressure();
      test_random_polygons();

      wait_drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0 && results_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Guard against a hang.
   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
